// File: hw/rtl/servo_bus_packet_framer_defines.svh
// Assertion macros used by the framer's emitter.
// Unless SYNTH is defined, each macro expands to one labelled concurrent assertion that
// is clocked on the rising edge and switched off while reset is high; with SYNTH it is empty.
`ifndef SERVO_BUS_PACKET_FRAMER_DEFINES_SVH
`define SERVO_BUS_PACKET_FRAMER_DEFINES_SVH

`ifndef SYNTH
`define SBPF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbpf: assertion failed");
`define SBPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbpf: assertion failed");
`else
`define SBPF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SBPF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/sbpf_pkg.sv
`default_nettype none

package sbpf_pkg;

  // Fixed bytes of the packet header.
  localparam logic [7:0] HDR_SYNC = 8'hFF;
  localparam logic [7:0] HDR_MARK = 8'hFD;
  localparam logic [7:0] HDR_RSVD = 8'h00;

  // CRC-16 generator polynomial, processed MSB first.
  localparam logic [15:0] CRC_POLY = 16'h8005;

  // Which byte of the frame the emitter is about to send.
  typedef enum logic [3:0] {
    KIND_HDR0,
    KIND_HDR1,
    KIND_HDR2,
    KIND_HDR3,
    KIND_ID,
    KIND_LEN_LO,
    KIND_LEN_HI,
    KIND_BODY,
    KIND_CRC_LO,
    KIND_CRC_HI
  } kind_t;

  // One outgoing word with its framing flags.
  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic       last;
  } beat_t;

  // Advance the CRC over one byte, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sbpf_body_if.sv
`default_nettype none

// Channel carrying body bytes together with the per-packet header fields.
interface sbpf_body_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_id;
  logic [7:0] body_length;
  logic [7:0] body_byte;

  modport source (output valid, output packet_id, output body_length, output body_byte,
                  input ready);
  modport sink (input valid, input packet_id, input body_length, input body_byte,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sbpf_frame_if.sv
`default_nettype none

// Channel carrying the framed packet, one byte per word.
interface sbpf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_packet;
  logic       last_of_run;

  modport source (output valid, output out_byte, output end_of_packet, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input end_of_packet, input last_of_run,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sbpf_emitter.sv
`default_nettype none

`include "servo_bus_packet_framer_defines.svh"

// Holds one accepted body word and sends its frame bytes one per cycle while the output
// register takes them, keeping the running CRC and the count of body bytes still expected.
module sbpf_emitter #(
  parameter int unsigned MAX_BODY = 248
) (
  input  wire logic          clk,
  input  wire logic          rst,
  sbpf_body_if.sink          body,
  output      logic          emit_valid,
  output      sbpf_pkg::beat_t beat,
  input  wire logic          emit_take
);

  localparam logic [7:0] MaxLen = 8'(MAX_BODY);

  // Item and state registers.
  logic                item_valid;
  logic                item_valid_next;
  sbpf_pkg::kind_t     kind;
  sbpf_pkg::kind_t     kind_next;
  logic [7:0]          item_id;
  logic [7:0]          item_len;
  logic [7:0]          item_body;
  logic [7:0]          bytes_left;
  logic [7:0]          bytes_left_next;
  logic [15:0]         crc;
  logic [15:0]         crc_next;

  // Combinational helpers.
  logic [8:0]          len_field;
  logic [7:0]          cur_byte;
  logic                tracked;
  logic                is_last;
  logic                advance;
  logic                finish;
  logic                load;
  logic                first;
  logic [7:0]          bl_dec;
  logic [7:0]          bl_after;
  logic [7:0]          len_clamp;
  logic [15:0]         crc_base;
  sbpf_pkg::kind_t     kind_succ;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      kind       <= sbpf_pkg::KIND_HDR0;
      bytes_left <= 8'd0;
      crc        <= 16'd0;
    end else begin
      item_valid <= item_valid_next;
      kind       <= kind_next;
      bytes_left <= bytes_left_next;
      crc        <= crc_next;
    end
  end

  // Captured fields of the current word.
  always_ff @(posedge clk) begin
    if (load) begin
      item_id   <= body.packet_id;
      item_len  <= len_clamp;
      item_body <= body.body_byte;
    end
  end

  // Byte selection and CRC update for the current position in the frame.
  always_comb begin
    len_field = {1'b0, item_len} + 9'd2;
    tracked   = 1'b1;
    unique case (kind)
      sbpf_pkg::KIND_HDR0:   cur_byte = sbpf_pkg::HDR_SYNC;
      sbpf_pkg::KIND_HDR1:   cur_byte = sbpf_pkg::HDR_SYNC;
      sbpf_pkg::KIND_HDR2:   cur_byte = sbpf_pkg::HDR_MARK;
      sbpf_pkg::KIND_HDR3:   cur_byte = sbpf_pkg::HDR_RSVD;
      sbpf_pkg::KIND_ID:     cur_byte = item_id;
      sbpf_pkg::KIND_LEN_LO: cur_byte = len_field[7:0];
      sbpf_pkg::KIND_LEN_HI: cur_byte = {7'd0, len_field[8]};
      sbpf_pkg::KIND_BODY:   cur_byte = item_body;
      sbpf_pkg::KIND_CRC_LO: begin
        cur_byte = crc[7:0];
        tracked  = 1'b0;
      end
      sbpf_pkg::KIND_CRC_HI: begin
        cur_byte = crc[15:8];
        tracked  = 1'b0;
      end
      default: begin
        cur_byte = 8'd0;
        tracked  = 1'b0;
      end
    endcase
    crc_base = (kind == sbpf_pkg::KIND_HDR0) ? 16'd0 : crc;
  end

  // Next state and handshake.
  always_comb begin
    bl_dec = bytes_left - 8'd1;

    unique case (kind)
      sbpf_pkg::KIND_HDR0:   kind_succ = sbpf_pkg::KIND_HDR1;
      sbpf_pkg::KIND_HDR1:   kind_succ = sbpf_pkg::KIND_HDR2;
      sbpf_pkg::KIND_HDR2:   kind_succ = sbpf_pkg::KIND_HDR3;
      sbpf_pkg::KIND_HDR3:   kind_succ = sbpf_pkg::KIND_ID;
      sbpf_pkg::KIND_ID:     kind_succ = sbpf_pkg::KIND_LEN_LO;
      sbpf_pkg::KIND_LEN_LO: kind_succ = sbpf_pkg::KIND_LEN_HI;
      sbpf_pkg::KIND_LEN_HI: kind_succ = sbpf_pkg::KIND_BODY;
      sbpf_pkg::KIND_BODY:   kind_succ = sbpf_pkg::KIND_CRC_LO;
      sbpf_pkg::KIND_CRC_LO: kind_succ = sbpf_pkg::KIND_CRC_HI;
      sbpf_pkg::KIND_CRC_HI: kind_succ = sbpf_pkg::KIND_HDR0;
      default:               kind_succ = sbpf_pkg::KIND_HDR0;
    endcase

    // The word ends on the high CRC byte, or on a body byte that is not the last one.
    is_last = (kind == sbpf_pkg::KIND_CRC_HI) ||
              ((kind == sbpf_pkg::KIND_BODY) && (bl_dec != 8'd0));
    advance = item_valid && emit_take;
    finish  = advance && is_last;

    body.ready = !item_valid || finish;
    load       = body.valid && body.ready;

    bl_after = (advance && (kind == sbpf_pkg::KIND_BODY)) ? bl_dec : bytes_left;
    first    = (bl_after == 8'd0);

    // A zero length counts as one; lengths above the limit are clamped.
    if (body.body_length == 8'd0) begin
      len_clamp = 8'd1;
    end else if (body.body_length > MaxLen) begin
      len_clamp = MaxLen;
    end else begin
      len_clamp = body.body_length;
    end

    if (load) begin
      item_valid_next = 1'b1;
      kind_next       = first ? sbpf_pkg::KIND_HDR0 : sbpf_pkg::KIND_BODY;
    end else if (finish) begin
      item_valid_next = 1'b0;
      kind_next       = kind;
    end else begin
      item_valid_next = item_valid;
      kind_next       = advance ? kind_succ : kind;
    end

    bytes_left_next = (load && first) ? len_clamp : bl_after;
    crc_next        = (advance && tracked) ? sbpf_pkg::crc_byte(crc_base, cur_byte) : crc;

    emit_valid = item_valid;
    beat.data  = cur_byte;
    beat.eop   = (kind == sbpf_pkg::KIND_CRC_HI);
    beat.last  = is_last;
  end

  // Checks on the sequencing.
  `SBPF_ASSERT_IMPLIES(a_eop_is_last, clk, rst, emit_valid && beat.eop, beat.last)
  `SBPF_ASSERT_NEXT(a_crc_lo_then_hi, clk, rst, advance && (kind == sbpf_pkg::KIND_CRC_LO), item_valid && (kind == sbpf_pkg::KIND_CRC_HI))
  `SBPF_ASSERT_IMPLIES(a_count_bounded, clk, rst, 1'b1, bytes_left <= MaxLen)
  `SBPF_ASSERT_IMPLIES(a_count_live, clk, rst, item_valid && (kind != sbpf_pkg::KIND_CRC_LO) && (kind != sbpf_pkg::KIND_CRC_HI), bytes_left != 8'd0)

endmodule

`default_nettype wire

// File: hw/rtl/sbpf_out_reg.sv
`default_nettype none

// Output register between the emitter and the frame channel.
module sbpf_out_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            emit_valid,
  input  wire sbpf_pkg::beat_t beat,
  output      logic            emit_take,
  sbpf_frame_if.source         frame
);

  logic            out_valid;
  sbpf_pkg::beat_t out_beat;

  // The register takes a new word whenever it is empty or being drained.
  assign emit_take = !out_valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_take) begin
      out_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take && emit_valid) begin
      out_beat <= beat;
    end
  end

  assign frame.valid         = out_valid;
  assign frame.out_byte      = out_beat.data;
  assign frame.end_of_packet = out_beat.eop;
  assign frame.last_of_run   = out_beat.last;

endmodule

`default_nettype wire

// File: hw/rtl/servo_bus_packet_framer.sv
// Channel | Role | Word contents
// body    | sink | packet_id, body_length, body_byte
// frame   | src  | out_byte, end_of_packet, last_of_run
//
// A body word that continues a packet gives one frame byte, so such words pass at one per cycle
// unless the frame channel stalls. The first body word of a packet gives eight bytes (header,
// id, length, body), the last also the two CRC bytes; the word is held in the emitter until sent.
// The emitter feeds the output register one byte per cycle while it has room, so it sets the rate.
// Synchronous reset clears the held word, the CRC and the body count; no clearing pass.
// A stall on the frame channel holds the output register and the emitter, then the body side.
`default_nettype none

module servo_bus_packet_framer #(
  parameter int unsigned MAX_BODY = 248
) (
  input wire logic     clk,
  input wire logic     rst,
  sbpf_body_if.sink    body,
  sbpf_frame_if.source frame
);

  logic            emit_valid;
  logic            emit_take;
  sbpf_pkg::beat_t beat;

  // Frame sequencer with running CRC.
  sbpf_emitter #(
    .MAX_BODY(MAX_BODY)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .body      (body),
    .emit_valid(emit_valid),
    .beat      (beat),
    .emit_take (emit_take)
  );

  // Output register.
  sbpf_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .emit_valid(emit_valid),
    .beat      (beat),
    .emit_take (emit_take),
    .frame     (frame)
  );

endmodule

`default_nettype wire

// File: sim/servo_bus_packet_framer_tb.sv
`timescale 1ns / 100ps

module servo_bus_packet_framer_tb;

  localparam int unsigned MAX_BODY     = 248;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned RANDOM_WORDS = 120;
  localparam int unsigned HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sbpf_body_if  body_ch();
  sbpf_frame_if frame_ch();

  servo_bus_packet_framer #(
    .MAX_BODY(MAX_BODY)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .body (body_ch),
    .frame(frame_ch)
  );

  // Framer state as the predictor sees it.
  logic [15:0]     frame_crc;
  logic [7:0]      body_left;
  sbpf_pkg::beat_t frame_bytes_due[$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          src_idle_on;
  bit          sink_idle_on;
  int unsigned hold_off_request;

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // CRC-16 over one byte, feedback taken bit by bit from the most significant end.
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ sbpf_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  // Queue one expected frame byte, folding it into the CRC when it is covered.
  function void queue_frame_byte(logic [7:0] data, logic eop, bit covered);
    sbpf_pkg::beat_t b;
    if (covered) begin
      frame_crc = crc16_update(frame_crc, data);
    end
    b.data = data;
    b.eop  = eop;
    b.last = 1'b0;
    frame_bytes_due.push_back(b);
  endfunction

  // Work out every frame byte that one accepted body word causes.
  function void predict_frame_bytes(logic [7:0] id, logic [7:0] len_field, logic [7:0] data);
    logic [7:0]      len;
    logic [15:0]     wire_len;
    logic [15:0]     crc;
    sbpf_pkg::beat_t tail;
    if (body_left == 8'd0) begin
      len = len_field;
      if (len == 8'd0) begin
        len = 8'd1;
      end
      if (len > MAX_BODY) begin
        len = 8'(MAX_BODY);
      end
      wire_len  = 16'(len) + 16'd2;
      frame_crc = '0;
      queue_frame_byte(sbpf_pkg::HDR_SYNC, 1'b0, 1'b1);
      queue_frame_byte(sbpf_pkg::HDR_SYNC, 1'b0, 1'b1);
      queue_frame_byte(sbpf_pkg::HDR_MARK, 1'b0, 1'b1);
      queue_frame_byte(sbpf_pkg::HDR_RSVD, 1'b0, 1'b1);
      queue_frame_byte(id, 1'b0, 1'b1);
      queue_frame_byte(wire_len[7:0], 1'b0, 1'b1);
      queue_frame_byte(wire_len[15:8], 1'b0, 1'b1);
      body_left = len;
    end
    queue_frame_byte(data, 1'b0, 1'b1);
    body_left = body_left - 8'd1;
    if (body_left == 8'd0) begin
      crc = frame_crc;
      queue_frame_byte(crc[7:0], 1'b0, 1'b0);
      queue_frame_byte(crc[15:8], 1'b1, 1'b0);
    end
    tail = frame_bytes_due.pop_back();
    tail.last = 1'b1;
    frame_bytes_due.push_back(tail);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Compare one accepted frame word with the oldest expected byte.
  task automatic check_frame_word();
    sbpf_pkg::beat_t want;
    if (frame_bytes_due.size() == 0) begin
      note_mismatch($sformatf("out_byte %h arrived with nothing expected", frame_ch.out_byte));
    end else begin
      want = frame_bytes_due.pop_front();
      if (frame_ch.out_byte !== want.data) begin
        note_mismatch($sformatf("out_byte expected %h, got %h", want.data, frame_ch.out_byte));
      end
      if (frame_ch.end_of_packet !== want.eop) begin
        note_mismatch($sformatf("end_of_packet expected %b, got %b", want.eop,
                                frame_ch.end_of_packet));
      end
      if (frame_ch.last_of_run !== want.last) begin
        note_mismatch($sformatf("last_of_run expected %b, got %b", want.last,
                                frame_ch.last_of_run));
      end
    end
  endtask

  // Offer one body word, wait for it to be taken, then perhaps leave a gap.
  task automatic send_word(logic [7:0] id, logic [7:0] len_field, logic [7:0] data);
    int unsigned gap;
    body_ch.valid       <= 1'b1;
    body_ch.packet_id   <= id;
    body_ch.body_length <= len_field;
    body_ch.body_byte   <= data;
    do @(posedge clk); while (body_ch.ready !== 1'b1);
    predict_frame_bytes(id, len_field, data);
    gap = src_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      body_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send a whole packet; the header fields of later words are random and must be ignored.
  task automatic send_packet(logic [7:0] id, logic [7:0] len_field);
    int unsigned n;
    n = (len_field == 8'd0) ? 1 : ((len_field > MAX_BODY) ? MAX_BODY : len_field);
    send_word(id, len_field, 8'($urandom));
    for (int unsigned i = 1; i < n; i++) begin
      send_word(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Stop offering words and wait until every expected byte has come out.
  task automatic wait_drained();
    body_ch.valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
  endtask

  // Single-word packets at the field extremes, a zero length, and header fields that
  // change in the middle of a packet.
  task automatic test_short_packets();
    send_word(8'h00, 8'd1, 8'h00);
    send_word(8'hFF, 8'd1, 8'hFF);
    send_word(8'h5A, 8'd0, 8'h81);
    send_word(8'hFE, 8'd3, 8'hFF);
    send_word(8'h01, 8'hFF, 8'h00);
    send_word(8'h80, 8'h00, 8'h7E);
    send_word(8'hFD, 8'd2, 8'h55);
    send_word(8'hFF, 8'hF8, 8'hAA);
    send_word(8'h33, 8'd4, 8'h01);
    send_word(8'hCC, 8'd7, 8'h80);
    send_word(8'h0F, 8'd1, 8'hFE);
    send_word(8'hF0, 8'd6, 8'h7F);
  endtask

  // The longest body, once exactly and once from a length that has to be clamped.
  task automatic test_longest_packets();
    send_packet(8'hFE, 8'd248);
    send_packet(8'h07, 8'd255);
  endtask

  // Back-to-back words with neither side idling.
  task automatic test_full_rate();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    send_packet(8'h11, 8'd1);
    send_packet(8'h22, 8'd2);
    send_packet(8'h33, 8'd5);
    send_packet(8'h44, 8'd16);
    send_packet(8'h55, 8'd1);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering words,
  // then the sender waits until every expected byte has come out.
  task automatic test_output_hold_off();
    wait_drained();
    src_idle_on      = 1'b0;
    hold_off_request = HOLD_CYCLES;
    send_packet(8'hA5, 8'd24);
    send_packet(8'h5A, 8'd3);
    src_idle_on = 1'b1;
    wait_drained();
  endtask

  // Well-formed packets of random content, mostly short, with idling switched on and off.
  task automatic test_random_packets();
    int unsigned sent;
    int unsigned r;
    logic [7:0]  len;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      r = $urandom_range(99, 0);
      if (r < 70) begin
        len = 8'($urandom_range(6, 1));
      end else if (r < 95) begin
        len = 8'($urandom_range(40, 7));
      end else begin
        len = 8'd0;
      end
      send_packet(8'($urandom), len);
      sent += (len == 8'd0) ? 1 : len;
      if ($urandom_range(9, 0) == 0) begin
        src_idle_on = !src_idle_on;
      end
      if ($urandom_range(9, 0) == 0) begin
        sink_idle_on = !sink_idle_on;
      end
      if ($urandom_range(19, 0) == 0) begin
        wait_drained();
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Receiver: check each accepted word, then choose ready for the next cycle.
  initial begin : frame_sink
    int unsigned stall_left;
    int unsigned gap_left;
    stall_left     = 0;
    gap_left       = 0;
    frame_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) begin
        check_frame_word();
      end
      if (hold_off_request != 0) begin
        stall_left       = hold_off_request;
        hold_off_request = 0;
      end
      if (stall_left != 0) begin
        stall_left--;
        frame_ch.ready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        frame_ch.ready <= 1'b0;
      end else begin
        frame_ch.ready <= 1'b1;
        if (sink_idle_on) begin
          gap_left = pick_gap();
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL servo_bus_packet_framer");
    $finish;
  end

  // Test sequence.
  initial begin : run_tests
    body_ch.valid       = 1'b0;
    body_ch.packet_id   = 8'h00;
    body_ch.body_length = 8'h00;
    body_ch.body_byte   = 8'h00;
    src_idle_on         = 1'b1;
    sink_idle_on        = 1'b1;
    hold_off_request    = 0;
    mismatch_count      = 0;
    frame_crc           = '0;
    body_left           = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_short_packets();
    test_longest_packets();
    test_full_rate();
    test_output_hold_off();
    test_random_packets();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
      $display("PASS servo_bus_packet_framer");
    end else begin
      $display("FAIL servo_bus_packet_framer");
    end
    $finish;
  end

endmodule
